// ===== design/ldst_pkg.sv =====
// Shared constants and types of the load/store unit.
package ldst_pkg;

	// Byte store size: a power of two, at least 16.
	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned NUM_REGS  = 32;
	localparam int unsigned XLEN      = 64;
	localparam int unsigned INSTR_W   = 32;
	localparam int unsigned LANES     = 8;
	localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
	localparam int unsigned ROWS      = MEM_BYTES / LANES;
	localparam int unsigned ROW_W     = $clog2(ROWS);
	localparam int unsigned REG_W     = $clog2(NUM_REGS);
	localparam int unsigned LANE_W    = $clog2(LANES);

	typedef logic [REG_W-1:0]   reg_idx_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [LANE_W-1:0]  lane_t;
	typedef logic [XLEN-1:0]    xword_t;
	typedef logic [INSTR_W-1:0] instr_t;

endpackage

// ===== design/ldst_if.sv =====
// Handshake channels of the load/store unit: instruction issue and result.
interface ldst_issue_if import ldst_pkg::*; ();
	logic   valid;
	logic   ready;
	instr_t instr_word;
	xword_t prog_counter;

	modport source (output valid, output instr_word, output prog_counter, input ready);
	modport sink   (input valid, input instr_word, input prog_counter, output ready);
endinterface

interface ldst_result_if import ldst_pkg::*; ();
	logic   valid;
	logic   ready;
	xword_t eff_address;
	xword_t moved_data;
	logic   was_load;
	logic   base_updated;
	logic   addr_wrapped;

	modport source (output valid, output eff_address, output moved_data, output was_load,
		output base_updated, output addr_wrapped, input ready);
	modport sink   (input valid, input eff_address, input moved_data, input was_load,
		input base_updated, input addr_wrapped, output ready);
endinterface

// ===== design/ldst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module ldst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read at the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/aarch64_load_store_unit.sv =====
// Top level of the AArch64 LDR/STR unit: decode, address, register file and byte store.
//
//  channel  | dir | word                                   | accepted when
//  ---------+-----+----------------------------------------+------------------------
//  issue    | in  | instr_word, prog_counter               | issue.valid & issue.ready
//  result   | out | eff_address, moved_data, was_load,     | result.valid & result.ready
//           |     | base_updated, addr_wrapped             |
//
// Issue waits for an empty stage 1 and a stage 2 that can move on; a result waiting
// in the output register stalls stage 2 and then issue.ready. Registers are read into
// stage 1, bytes into stage 2; write-back happens as the word leaves each stage. After
// reset a clearing pass zeroes the byte store, MEM_BYTES/8 rows (8192 here), with
// issue.ready low. The register file starts as zero through per-entry valid bits.
module aarch64_load_store_unit import ldst_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	ldst_issue_if.sink    issue,
	ldst_result_if.source result
);

	localparam logic [ADDR_W:0] MEM_SPAN = (ADDR_W + 1)'(MEM_BYTES);
	localparam logic [ADDR_W:0] SPAN_8   = (ADDR_W + 1)'(8);
	localparam logic [ADDR_W:0] SPAN_4   = (ADDR_W + 1)'(4);
	localparam row_t            LAST_ROW = row_t'(ROWS - 1);
	localparam lane_t           HALF_LN  = lane_t'(LANES / 2);

	// control state
	logic                clr_busy_q;
	row_t                clr_row_q;
	logic                vld_s1;
	logic                vld_s2;
	logic                out_vld_q;
	logic [NUM_REGS-1:0] rvalid_q;
	logic                fwd_vld_q;
	reg_idx_t            fwd_idx_q;
	xword_t              fwd_data_q;

	// pipeline payload
	instr_t instr_s1;
	xword_t pc_s1;
	xword_t addr_s2;
	xword_t data_s2;
	logic   load_s2;
	logic   wide_s2;
	logic   wb_s2;
	logic   wrap_s2;
	reg_idx_t rt_s2;
	lane_t  off_s2;

	xword_t out_addr_q;
	xword_t out_data_q;
	logic   out_load_q;
	logic   out_wb_q;
	logic   out_wrap_q;

	// handshake
	logic issue_acc;
	logic s2_move;

	// register file ports
	xword_t   rd_n, rd_m, rd_t;
	logic     reg_we;
	reg_idx_t reg_waddr;
	xword_t   reg_wdata;

	// stage 1 decode and address
	reg_idx_t rn_s1, rm_s1, rt_s1;
	xword_t   xn, xm, xt;
	logic     lit_c, wide_c, load_c, wb_c, pre_c;
	xword_t   opa, opb, sum_c, addr_c, st_raw, st_data;
	logic [ADDR_W:0] span_c;
	logic     wrap_c;
	row_t     row_c, row_nx;
	lane_t    off_c;

	// byte store lanes
	logic [LANES-1:0] lane_we;
	logic             lane_re;
	row_t             lane_wa [LANES];
	row_t             lane_ra [LANES];
	logic [7:0]       lane_wd [LANES];
	logic [7:0]       lane_rd [LANES];

	xword_t ld_data;

	assign issue_acc    = issue.valid && issue.ready;
	assign s2_move      = vld_s2 && (!out_vld_q || result.ready);
	assign issue.ready  = !clr_busy_q && !vld_s1 && (!vld_s2 || s2_move);

	// ---------------- register file: three read copies, one shared write ----------------
	ldst_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_xn_ram (
		.clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
		.re(issue_acc), .raddr(issue.instr_word[9:5]), .rdata(rd_n)
	);
	ldst_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_xm_ram (
		.clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
		.re(issue_acc), .raddr(issue.instr_word[20:16]), .rdata(rd_m)
	);
	ldst_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_xt_ram (
		.clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
		.re(issue_acc), .raddr(issue.instr_word[4:0]), .rdata(rd_t)
	);

	assign rn_s1 = instr_s1[9:5];
	assign rm_s1 = instr_s1[20:16];
	assign rt_s1 = instr_s1[4:0];

	// a load written back on the issue edge is missed by the read-first RAM
	assign xn = (fwd_vld_q && fwd_idx_q == rn_s1) ? fwd_data_q :
		(rvalid_q[rn_s1] ? rd_n : '0);
	assign xm = (fwd_vld_q && fwd_idx_q == rm_s1) ? fwd_data_q :
		(rvalid_q[rm_s1] ? rd_m : '0);
	assign xt = (fwd_vld_q && fwd_idx_q == rt_s1) ? fwd_data_q :
		(rvalid_q[rt_s1] ? rd_t : '0);

	// ---------------- stage 1: decode and effective address ----------------
	always_comb begin
		lit_c  = !instr_s1[31];
		wide_c = instr_s1[30];
		load_c = lit_c || instr_s1[22];
		wb_c   = !lit_c && !instr_s1[24] && !instr_s1[21];
		pre_c  = instr_s1[11];

		opa = lit_c ? pc_s1 : xn;
		if (lit_c) begin
			opb = {{43{instr_s1[23]}}, instr_s1[23:5], 2'b00};
		end else if (instr_s1[24]) begin
			opb = wide_c ? {49'd0, instr_s1[21:10], 3'b000} : {50'd0, instr_s1[21:10], 2'b00};
		end else if (instr_s1[21]) begin
			opb = xm;
		end else begin
			opb = {{55{instr_s1[20]}}, instr_s1[20:12]};
		end
		sum_c  = opa + opb;
		addr_c = (wb_c && !pre_c) ? xn : sum_c;

		// store sends the updated base when base and target coincide
		st_raw  = (wb_c && rt_s1 == rn_s1) ? sum_c : xt;
		st_data = wide_c ? st_raw : {32'd0, st_raw[31:0]};

		span_c = {1'b0, addr_c[ADDR_W-1:0]} + (wide_c ? SPAN_8 : SPAN_4);
		wrap_c = (|addr_c[XLEN-1:ADDR_W]) || (span_c > MEM_SPAN);

		row_c  = addr_c[ADDR_W-1:LANE_W];
		off_c  = addr_c[LANE_W-1:0];
		row_nx = row_c + row_t'(1);
	end

	// ---------------- byte store: eight byte lanes ----------------
	assign lane_re = vld_s1 && load_c;

	always_comb begin
		lane_t idx;
		for (int l = 0; l < LANES; l++) begin
			idx        = lane_t'(l) - off_c;
			lane_ra[l] = (lane_t'(l) < off_c) ? row_nx : row_c;
			if (clr_busy_q) begin
				lane_we[l] = 1'b1;
				lane_wa[l] = clr_row_q;
				lane_wd[l] = 8'h00;
			end else begin
				lane_we[l] = vld_s1 && !load_c && (wide_c || idx < HALF_LN);
				lane_wa[l] = lane_ra[l];
				lane_wd[l] = st_data[{idx, 3'b000} +: 8];
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ldst_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane_ram (
			.clk(clk), .we(lane_we[g]), .waddr(lane_wa[g]), .wdata(lane_wd[g]),
			.re(lane_re), .raddr(lane_ra[g]), .rdata(lane_rd[g])
		);
	end

	// ---------------- stage 2: gather the loaded bytes ----------------
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ld_data[i*8 +: 8] = (wide_s2 || i < LANES / 2) ?
				lane_rd[off_s2 + lane_t'(i)] : 8'h00;
		end
	end

	// base write-back leaves stage 1, load write-back leaves stage 2; never together
	always_comb begin
		if (s2_move && load_s2) begin
			reg_we    = 1'b1;
			reg_waddr = rt_s2;
			reg_wdata = ld_data;
		end else begin
			reg_we    = vld_s1 && wb_c;
			reg_waddr = rn_s1;
			reg_wdata = sum_c;
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			out_vld_q  <= 1'b0;
			rvalid_q   <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + row_t'(1);
				if (clr_row_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end
			end
			vld_s1 <= issue_acc;
			if (vld_s1) begin
				vld_s2 <= 1'b1;
			end else if (s2_move) begin
				vld_s2 <= 1'b0;
			end
			if (s2_move) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (reg_we) begin
				rvalid_q[reg_waddr] <= 1'b1;
			end
			fwd_vld_q <= s2_move && load_s2;
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (issue_acc) begin
			instr_s1 <= issue.instr_word;
			pc_s1    <= issue.prog_counter;
		end
		if (vld_s1) begin
			addr_s2 <= addr_c;
			data_s2 <= st_data;
			load_s2 <= load_c;
			wide_s2 <= wide_c;
			wb_s2   <= wb_c;
			wrap_s2 <= wrap_c;
			rt_s2   <= rt_s1;
			off_s2  <= off_c;
		end
		if (s2_move) begin
			out_addr_q <= addr_s2;
			out_data_q <= load_s2 ? ld_data : data_s2;
			out_load_q <= load_s2;
			out_wb_q   <= wb_s2;
			out_wrap_q <= wrap_s2;
			fwd_idx_q  <= rt_s2;
			fwd_data_q <= ld_data;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.eff_address  = out_addr_q;
	assign result.moved_data   = out_data_q;
	assign result.was_load     = out_load_q;
	assign result.base_updated = out_wb_q;
	assign result.addr_wrapped = out_wrap_q;

	// ---------------- assertions ----------------
	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2))
		else $error("stage 1 and stage 2 occupied together");

	a_s1_single: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> (vld_s2 && !vld_s1))
		else $error("stage 1 word did not move on after one cycle");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!issue.ready && !vld_s1 && !vld_s2))
		else $error("instruction in flight during byte store clearing");

endmodule
